FILE: src/eul2rot_pkg.sv
// Package: types and constants for the Euler angle to rotation matrix block
`timescale 1ns / 1ps
package eul2rot_pkg;

   localparam int WFRAC = 30;
   localparam int ATAN_ENTRIES = 24;
   // Q30 datapath word: sign, guard and integer bits plus 30 fraction bits
   localparam int DW = 34;

   localparam logic signed [DW-1:0] KINV_Q30 = 34'sh026DD3B6A;
   localparam logic signed [DW-1:0] PI_Q30 = 34'sd3373259426;
   localparam logic signed [DW-1:0] HALF_PI_Q30 = 34'sd1686629713;

   typedef struct packed {
      logic signed [15:0] yaw;
      logic signed [15:0] pitch;
      logic signed [15:0] roll;
   } req_type;

   typedef struct packed {
      logic signed [15:0] m00;
      logic signed [15:0] m01;
      logic signed [15:0] m02;
      logic signed [15:0] m10;
      logic signed [15:0] m11;
      logic signed [15:0] m12;
      logic signed [15:0] m20;
      logic signed [15:0] m21;
      logic signed [15:0] m22;
   } rsp_type;

   function automatic logic signed [DW-1:0] atan_q30(input logic [4:0] idx);
      logic signed [DW-1:0] v;
      case (idx)
         5'd0: v = 34'sh03243F6A8;
         5'd1: v = 34'sh01DAC6705;
         5'd2: v = 34'sh00FADBAFC;
         5'd3: v = 34'sh007F56EA6;
         5'd4: v = 34'sh003FEAB76;
         5'd5: v = 34'sh001FFD55B;
         5'd6: v = 34'sh000FFFAAA;
         5'd7: v = 34'sh0007FFF55;
         5'd8: v = 34'sh0003FFFEA;
         5'd9: v = 34'sh0001FFFFD;
         5'd10: v = 34'sh0000FFFFF;
         5'd11: v = 34'sh00007FFFF;
         5'd12: v = 34'sh00003FFFF;
         5'd13: v = 34'sh00001FFFF;
         5'd14: v = 34'sh00000FFFF;
         5'd15: v = 34'sh000007FFF;
         5'd16: v = 34'sh000003FFF;
         5'd17: v = 34'sh000001FFF;
         5'd18: v = 34'sh000000FFF;
         5'd19: v = 34'sh0000007FF;
         5'd20: v = 34'sh0000003FF;
         5'd21: v = 34'sh0000001FF;
         5'd22: v = 34'sh0000000FF;
         5'd23: v = 34'sh00000007F;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

FILE: src/eul2rot_cordic.sv
// Pipelined rotation-mode CORDIC: sine and cosine of one Q3.13 angle, Q30 out
`timescale 1ns / 1ps
module eul2rot_cordic
   import eul2rot_pkg::*;
#(
   parameter int STAGES = 16
) (
   input  logic                 clock,
   input  logic                 enable,
   input  logic signed [15:0]   angle,
   output logic signed [DW-1:0] sin_q30,
   output logic signed [DW-1:0] cos_q30
);

   // stage 0 holds the folded angle, stage k holds the result of k rotations
   logic signed [DW-1:0] x_ff [STAGES+1];
   logic signed [DW-1:0] y_ff [STAGES+1];
   logic signed [DW-1:0] z_ff [STAGES+1];
   logic                 flip_ff [STAGES+1];

   logic signed [DW-1:0] z0_in;
   logic signed [DW-1:0] zf_in;
   logic                 flip_in;

   always_comb begin
      z0_in = {{(DW-30){angle[15]}}, angle, 14'b0} <<< 3;
      zf_in = z0_in;
      flip_in = 1'b0;
      if (z0_in > HALF_PI_Q30) begin
         zf_in = z0_in - PI_Q30;
         flip_in = 1'b1;
      end else if (z0_in < -HALF_PI_Q30) begin
         zf_in = z0_in + PI_Q30;
         flip_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         x_ff[0] <= KINV_Q30;
         y_ff[0] <= '0;
         z_ff[0] <= zf_in;
         flip_ff[0] <= flip_in;
      end
   end

   for (genvar i = 0; i < STAGES; i++) begin : g_stage
      always_ff @(posedge clock) begin
         if (enable) begin
            if (!z_ff[i][DW-1]) begin
               x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] - atan_q30(5'(i));
            end else begin
               x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] + atan_q30(5'(i));
            end
            flip_ff[i+1] <= flip_ff[i];
         end
      end
   end

   assign cos_q30 = flip_ff[STAGES] ? -x_ff[STAGES] : x_ff[STAGES];
   assign sin_q30 = flip_ff[STAGES] ? -y_ff[STAGES] : y_ff[STAGES];

endmodule

FILE: src/euler_to_rotation_matrix_top.sv
// Top level: Euler angles (yaw, pitch, roll) to a 3x3 rotation matrix
// Registers: CORDIC, first products, second products, sums, output (stages capped at 24).
// Throughput: one item per cycle unless stalled; each CORDIC stage is one register stage.
// A stall freezes the whole pipeline; nothing is lost or repeated.
// Reset clears the valid bits only; the datapath needs no reset.
`timescale 1ns / 1ps
module euler_to_rotation_matrix_top
   import eul2rot_pkg::*;
#(
   parameter int CORDIC_STAGES = 16,
   parameter int OUT_FRAC_BITS = 14
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int NST = (CORDIC_STAGES > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STAGES;
   // cordic (NST+1) + product1 + product2 + sum + round = NST+5 register stages
   localparam int DEPTH = NST + 5;
   localparam int SHIFT = WFRAC - OUT_FRAC_BITS;
   localparam int PW = 2 * DW;

   logic advance;
   logic [DEPTH-1:0] vld_ff;
   logic [DEPTH-1:0] vld_in;

   // whole pipeline moves unless the output item is held
   assign advance = !(rsp_valid && rsp_stall);
   assign req_stall = !advance;
   assign rsp_valid = vld_ff[DEPTH-1];

   always_comb begin
      vld_in = {vld_ff[DEPTH-2:0], req_valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= vld_in;
      end
   end

   logic signed [DW-1:0] sy, cy, sp, cp, sr, cr;

   eul2rot_cordic #(.STAGES(NST)) u_yaw (
      .clock(clock), .enable(advance), .angle(req_data.yaw), .sin_q30(sy), .cos_q30(cy));
   eul2rot_cordic #(.STAGES(NST)) u_pitch (
      .clock(clock), .enable(advance), .angle(req_data.pitch), .sin_q30(sp), .cos_q30(cp));
   eul2rot_cordic #(.STAGES(NST)) u_roll (
      .clock(clock), .enable(advance), .angle(req_data.roll), .sin_q30(sr), .cos_q30(cr));

   function automatic logic signed [DW-1:0] mul30(input logic signed [DW-1:0] a,
                                                  input logic signed [DW-1:0] b);
      logic signed [PW-1:0] p;
      p = PW'(a) * PW'(b) + (PW'(1) <<< (WFRAC - 1));
      return DW'(p >>> WFRAC);
   endfunction

   // first products
   logic signed [DW-1:0] sysp_ff, cysp_ff, m02_ff, m10_ff, m11_ff, m12_ff, m22_ff;
   logic signed [DW-1:0] cycr_ff, cysr_ff, sycr_ff, sysr_ff;
   logic signed [DW-1:0] sr1_ff, cr1_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         sysp_ff <= mul30(sy, sp);
         cysp_ff <= mul30(cy, sp);
         m02_ff <= mul30(sy, cp);
         m10_ff <= mul30(cp, sr);
         m11_ff <= mul30(cp, cr);
         m12_ff <= -sp;
         m22_ff <= mul30(cy, cp);
         cycr_ff <= mul30(cy, cr);
         cysr_ff <= mul30(cy, sr);
         sycr_ff <= mul30(sy, cr);
         sysr_ff <= mul30(sy, sr);
         sr1_ff <= sr;
         cr1_ff <= cr;
      end
   end

   // second products
   logic signed [DW-1:0] a00_ff, a01_ff, a20_ff, a21_ff;
   logic signed [DW-1:0] b00_ff, b01_ff, b20_ff, b21_ff;
   logic signed [DW-1:0] c02_ff, c10_ff, c11_ff, c12_ff, c22_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         a00_ff <= cycr_ff;
         b00_ff <= mul30(sysp_ff, sr1_ff);
         a01_ff <= mul30(sysp_ff, cr1_ff);
         b01_ff <= cysr_ff;
         a20_ff <= mul30(cysp_ff, sr1_ff);
         b20_ff <= sycr_ff;
         a21_ff <= sysr_ff;
         b21_ff <= mul30(cysp_ff, cr1_ff);
         c02_ff <= m02_ff;
         c10_ff <= m10_ff;
         c11_ff <= m11_ff;
         c12_ff <= m12_ff;
         c22_ff <= m22_ff;
      end
   end

   // sums
   logic signed [DW-1:0] s_ff [9];

   always_ff @(posedge clock) begin
      if (advance) begin
         s_ff[0] <= a00_ff + b00_ff;
         s_ff[1] <= a01_ff - b01_ff;
         s_ff[2] <= c02_ff;
         s_ff[3] <= c10_ff;
         s_ff[4] <= c11_ff;
         s_ff[5] <= c12_ff;
         s_ff[6] <= a20_ff - b20_ff;
         s_ff[7] <= a21_ff + b21_ff;
         s_ff[8] <= c22_ff;
      end
   end

   function automatic logic signed [15:0] to_out(input logic signed [DW-1:0] v);
      logic signed [DW:0] r;
      logic signed [DW:0] lim;
      r = (DW+1)'(v);
      if (SHIFT > 0) begin
         r = (r + ((DW+1)'(1) <<< (SHIFT - 1))) >>> SHIFT;
      end
      lim = (DW+1)'(1) <<< OUT_FRAC_BITS;
      if (r > lim) r = lim;
      if (r < -lim) r = -lim;
      if (r > 32767) r = 32767;
      if (r < -32768) r = -32768;
      return 16'(r);
   endfunction

   rsp_type out_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff.m00 <= to_out(s_ff[0]);
         out_ff.m01 <= to_out(s_ff[1]);
         out_ff.m02 <= to_out(s_ff[2]);
         out_ff.m10 <= to_out(s_ff[3]);
         out_ff.m11 <= to_out(s_ff[4]);
         out_ff.m12 <= to_out(s_ff[5]);
         out_ff.m20 <= to_out(s_ff[6]);
         out_ff.m21 <= to_out(s_ff[7]);
         out_ff.m22 <= to_out(s_ff[8]);
      end
   end

   assign rsp_data = out_ff;

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("held result changed");
   a_stall_freezes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(vld_ff))
      else $error("pipeline moved while stalled");
   a_req_stall: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("input stalled with no held result");

endmodule
